// ===== design/xru_pkg.sv =====
// ============================================================================
// xru_pkg
// Shared types, codes and the opcode table of the XOR region unpacker.
// ============================================================================
package xru_pkg;

    localparam int DATA_W    = 8;
    localparam int SCORE_W   = 9;
    localparam int KIND_W    = 2;
    localparam int MODE_W    = 2;
    localparam int KEY_LEN_W = 5;
    localparam int REG_IDX_W = 4;
    localparam int REG_DAT_W = 64;
    localparam int NUM_KEYS  = 255;
    localparam int NUM_OPS   = 15;

    localparam logic [MODE_W-1:0] MODE_REPEAT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ROLL   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DETECT = 2'd2;

    localparam logic [KIND_W-1:0] KIND_PLAIN = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FOUND = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FAIL  = 2'd2;

    localparam logic [REG_IDX_W-1:0] REG_MODE     = 4'd0;
    localparam logic [REG_IDX_W-1:0] REG_KEY_LEN  = 4'd1;
    localparam logic [REG_IDX_W-1:0] REG_KEY_LOW  = 4'd2;
    localparam logic [REG_IDX_W-1:0] REG_KEY_HIGH = 4'd3;

    localparam logic [SCORE_W-1:0] FAIL_SCORE = 9'd20;

    localparam logic [DATA_W-1:0] OPCODES [NUM_OPS] = '{
        8'h48, 8'h49, 8'h4C, 8'h55, 8'h53, 8'h56, 8'h41, 8'h89,
        8'h8B, 8'hE8, 8'hE9, 8'hEB, 8'hC3, 8'hCC, 8'h90
    };

    // Score token that walks down the cell row during a key search.
    typedef struct packed {
        logic               vld;
        logic [SCORE_W-1:0] score;
        logic [DATA_W-1:0]  key;
    } t_token;

    typedef enum logic {
        ST_RUN,
        ST_SWEEP
    } t_state;

    function automatic logic is_opcode(input logic [DATA_W-1:0] value);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < NUM_OPS; i++) begin
            if (value == OPCODES[i]) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

endpackage

// ===== design/xru_in_if.sv =====
// ============================================================================
// xru_in_if
// Input byte channel: one region byte and its end-of-region flag.
// ============================================================================
interface xru_in_if;
    import xru_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data_byte;
    logic              last;

    modport source (output valid, output data_byte, output last, input ready);
    modport sink   (input valid, input data_byte, input last, output ready);
endinterface

// ===== design/xru_out_if.sv =====
// ============================================================================
// xru_out_if
// Result channel: decoded byte or key search outcome.
// ============================================================================
interface xru_out_if;
    import xru_pkg::*;

    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  result_kind;
    logic [DATA_W-1:0]  plain_byte;
    logic [DATA_W-1:0]  found_key;
    logic [SCORE_W-1:0] top_score;
    logic               final_res;

    modport source (output valid, output result_kind, output plain_byte,
                    output found_key, output top_score, output final_res,
                    input ready);
    modport sink   (input valid, input result_kind, input plain_byte,
                    input found_key, input top_score, input final_res,
                    output ready);
endinterface

// ===== design/xru_cfg_if.sv =====
// ============================================================================
// xru_cfg_if
// Register write channel: register index and write data.
// ============================================================================
interface xru_cfg_if;
    import xru_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [REG_IDX_W-1:0] reg_index;
    logic [REG_DAT_W-1:0] write_data;

    modport source (output valid, output reg_index, output write_data, input ready);
    modport sink   (input valid, input reg_index, input write_data, output ready);
endinterface

// ===== design/xru_score_cell.sv =====
// ============================================================================
// xru_score_cell
// One key score counter plus one stage of the best-key search chain.
// ============================================================================
module xru_score_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [xru_pkg::DATA_W-1:0]  i_key,
    input  logic [xru_pkg::DATA_W-1:0]  i_byte,
    input  logic                        i_inc,
    input  logic                        i_clr,
    input  xru_pkg::t_token             i_tok,
    output xru_pkg::t_token             o_tok
);
    import xru_pkg::*;

    logic [SCORE_W-1:0] r_score;
    logic [SCORE_W-1:0] n_score;
    t_token             r_tok;
    t_token             n_tok;

    always_comb begin
        n_score = r_score;
        if (i_clr) begin
            n_score = '0;
        end else if (i_inc && is_opcode(i_byte ^ i_key) && (r_score != '1)) begin
            n_score = r_score + 1'b1;
        end
    end

    // Strictly greater keeps the lower key on a tie, since tokens walk upward.
    always_comb begin
        n_tok = i_tok;
        if (r_score > i_tok.score) begin
            n_tok.score = r_score;
            n_tok.key   = i_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_score   <= '0;
            r_tok.vld <= 1'b0;
        end else begin
            r_score <= n_score;
            r_tok   <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

// ===== design/xru_score_chain.sv =====
// ============================================================================
// xru_score_chain
// Row of score cells for keys 1 to 255; a launched token leaves the far end
// carrying the best key and its score.
// ============================================================================
module xru_score_chain (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [xru_pkg::DATA_W-1:0]  i_byte,
    input  logic                        i_inc,
    input  logic                        i_clr,
    input  logic                        i_launch,
    output xru_pkg::t_token             o_tok
);
    import xru_pkg::*;

    t_token tok [NUM_KEYS+1];

    // The search starts from key 1 with score zero, which is the answer when
    // every score is zero.
    always_comb begin
        tok[0].vld   = i_launch;
        tok[0].score = '0;
        tok[0].key   = DATA_W'(1);
    end

    for (genvar gi = 1; gi <= NUM_KEYS; gi++) begin : g_cell
        xru_score_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_key   (DATA_W'(gi)),
            .i_byte  (i_byte),
            .i_inc   (i_inc),
            .i_clr   (i_clr),
            .i_tok   (tok[gi-1]),
            .o_tok   (tok[gi])
        );
    end

    assign o_tok = tok[NUM_KEYS];

endmodule

// ===== design/xor_region_unpacker.sv =====
// ============================================================================
// xor_region_unpacker
// Repeating-key and rolling XOR decoder with single-byte key detection.
// ============================================================================
// In the two XOR modes one byte is taken per cycle and its decoded byte is
// offered on the result channel through an output register, so bytes stream at
// full rate while results are taken. In detect mode each byte updates all 255
// key scores in parallel. The byte that ends the probe (byte PROBE_LENGTH of
// the region or the last byte) starts a search token down the row of 255 score
// cells, one cell per cycle; that byte therefore occupies the block until the
// token leaves the row, during which no byte is accepted. Register writes are
// always taken. Scores are cleared in parallel at the end of a region.
module xor_region_unpacker #(
    parameter int MAX_KEY_BYTES = 16,
    parameter int PROBE_LENGTH  = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    xru_in_if.sink     i_in,
    xru_out_if.source  o_out,
    xru_cfg_if.sink    i_cfg
);
    import xru_pkg::*;

    localparam int POS_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
    localparam int PC_W  = $clog2(PROBE_LENGTH + 1);

    // Configuration
    logic [MODE_W-1:0]    r_mode;
    logic [KEY_LEN_W-1:0] r_key_len;
    logic [DATA_W-1:0]    r_key [MAX_KEY_BYTES];

    // Region state
    logic [POS_W-1:0]     r_pos;
    logic [POS_W-1:0]     n_pos;
    logic [DATA_W-1:0]    r_prev;
    logic [DATA_W-1:0]    n_prev;
    logic                 r_in_region;
    logic [PC_W-1:0]      r_probe;
    logic                 r_done;
    logic                 r_launch;
    logic                 r_last_pend;
    t_state               r_state;
    t_state               n_state;

    // Result register
    logic                 r_out_valid;
    logic [KIND_W-1:0]    r_kind;
    logic [DATA_W-1:0]    r_plain;
    logic [DATA_W-1:0]    r_fkey;
    logic [SCORE_W-1:0]   r_score;
    logic                 r_final;

    logic                 cfg_wr;
    logic                 in_ready;
    logic                 acc;
    logic                 det_step;
    logic                 trigger;
    logic                 sweep_end;
    logic                 region_clr;
    logic                 xor_res;
    logic [KEY_LEN_W-1:0] len_use;
    logic [KEY_LEN_W-1:0] pos_ext;
    logic [KEY_LEN_W-1:0] pos_inc;
    logic [POS_W-1:0]     pos_use;
    logic [DATA_W-1:0]    prev_use;
    logic [DATA_W-1:0]    xor_byte;
    t_token               tok_end;

    // ------------------------------------------------------------------------
    // Register writes
    // ------------------------------------------------------------------------
    assign i_cfg.ready = 1'b1;
    assign cfg_wr      = i_cfg.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_REPEAT;
            r_key_len <= KEY_LEN_W'(1);
        end else if (cfg_wr) begin
            if (i_cfg.reg_index == REG_MODE) begin
                r_mode <= i_cfg.write_data[MODE_W-1:0];
            end
            if (i_cfg.reg_index == REG_KEY_LEN) begin
                r_key_len <= i_cfg.write_data[KEY_LEN_W-1:0];
            end
        end
    end

    for (genvar gk = 0; gk < MAX_KEY_BYTES; gk++) begin : g_key
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_key[gk] <= '0;
            end else if (cfg_wr) begin
                if (gk < 8 && i_cfg.reg_index == REG_KEY_LOW) begin
                    r_key[gk] <= i_cfg.write_data[(gk % 8) * DATA_W +: DATA_W];
                end
                if (gk >= 8 && i_cfg.reg_index == REG_KEY_HIGH) begin
                    r_key[gk] <= i_cfg.write_data[(gk % 8) * DATA_W +: DATA_W];
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Control
    // ------------------------------------------------------------------------
    assign acc       = i_in.valid && in_ready;
    assign det_step  = acc && (r_mode == MODE_DETECT) && !r_done;
    assign trigger   = det_step &&
                       ((r_probe == PC_W'(PROBE_LENGTH - 1)) || i_in.last);
    assign sweep_end = (r_state == ST_SWEEP) && tok_end.vld;
    assign xor_res   = acc && ((r_mode == MODE_REPEAT) || (r_mode == MODE_ROLL));

    // A region ends with its last byte, unless that byte started a search; then
    // it ends when the search result is stored.
    assign region_clr = (acc && i_in.last && !trigger) || (sweep_end && r_last_pend);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_RUN: begin
                if (trigger) begin
                    n_state = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                if (tok_end.vld) begin
                    n_state = ST_RUN;
                end
            end
            default: n_state = ST_RUN;
        endcase
    end

    always_comb begin
        in_ready = 1'b0;
        unique case (r_state)
            ST_RUN:   in_ready = !r_out_valid || o_out.ready;
            ST_SWEEP: in_ready = 1'b0;
            default:  in_ready = 1'b0;
        endcase
    end

    assign i_in.ready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RUN;
            r_launch    <= 1'b0;
            r_last_pend <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_launch <= trigger;
            if (trigger) begin
                r_last_pend <= i_in.last;
            end
        end
    end

    // ------------------------------------------------------------------------
    // XOR datapath
    // ------------------------------------------------------------------------
    always_comb begin
        len_use = r_key_len;
        if (r_key_len == '0) begin
            len_use = KEY_LEN_W'(1);
        end else if (r_key_len > KEY_LEN_W'(MAX_KEY_BYTES)) begin
            len_use = KEY_LEN_W'(MAX_KEY_BYTES);
        end
    end

    // A position left beyond a shortened key restarts at key byte 0.
    assign pos_ext  = KEY_LEN_W'(r_pos);
    assign pos_use  = (pos_ext >= len_use) ? '0 : r_pos;
    assign pos_inc  = KEY_LEN_W'(pos_use) + 1'b1;
    assign prev_use = r_in_region ? r_prev : r_key[0];

    always_comb begin
        xor_byte = i_in.data_byte ^ prev_use;
        n_pos    = r_pos;
        n_prev   = prev_use;
        if (r_mode == MODE_REPEAT) begin
            xor_byte = i_in.data_byte ^ r_key[pos_use];
            n_pos    = (pos_inc >= len_use) ? '0 : pos_inc[POS_W-1:0];
        end
        if (r_mode == MODE_ROLL) begin
            n_prev = i_in.data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_prev      <= '0;
            r_in_region <= 1'b0;
            r_probe     <= '0;
            r_done      <= 1'b0;
        end else if (region_clr) begin
            r_pos       <= '0;
            r_prev      <= '0;
            r_in_region <= 1'b0;
            r_probe     <= '0;
            r_done      <= 1'b0;
        end else begin
            if (acc) begin
                r_pos       <= n_pos;
                r_prev      <= n_prev;
                r_in_region <= 1'b1;
            end
            if (det_step) begin
                r_probe <= r_probe + 1'b1;
            end
            if (sweep_end) begin
                r_done <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Key scores and search
    // ------------------------------------------------------------------------
    xru_score_chain u_chain (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte   (i_in.data_byte),
        .i_inc    (det_step),
        .i_clr    (region_clr),
        .i_launch (r_launch),
        .o_tok    (tok_end)
    );

    // ------------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (xor_res || sweep_end) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (xor_res) begin
            r_kind  <= KIND_PLAIN;
            r_plain <= xor_byte;
            r_fkey  <= '0;
            r_score <= '0;
            r_final <= i_in.last;
        end else if (sweep_end) begin
            r_kind  <= (tok_end.score < FAIL_SCORE) ? KIND_FAIL : KIND_FOUND;
            r_plain <= '0;
            r_fkey  <= tok_end.key;
            r_score <= tok_end.score;
            r_final <= r_last_pend;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.result_kind = r_kind;
    assign o_out.plain_byte  = r_plain;
    assign o_out.found_key   = r_fkey;
    assign o_out.top_score   = r_score;
    assign o_out.final_res   = r_final;

endmodule
